[design/three_axis_homing_kinematics_core_defines.svh]
// assertion macros for the homing kinematics core
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef THREE_AXIS_HOMING_KINEMATICS_CORE_DEFINES_SVH
`define THREE_AXIS_HOMING_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication
`define THKC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define THKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/thkc_pkg.sv]
// shared types and constants of the homing kinematics core
// no dependencies
package thkc_pkg;

    localparam int DIV_BW    = 62;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] E_BITS    = 6'd31;
    localparam logic [DIV_CNT_W-1:0] STEP_BITS = 6'd48;
    localparam logic [DIV_CNT_W-1:0] W_BITS    = 6'd62;

    // 1.7 in q16
    localparam logic [16:0] ACC_GAIN_Q16 = 17'd111411;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_MAX_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_ACCEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_RANGE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TOP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_BOTTOM     = 3'd5;

    localparam logic [30:0]        RST_SPEED        = 31'd1000;
    localparam logic [30:0]        RST_ACCEL        = 31'd1000;
    localparam logic [30:0]        RST_RANGE        = 31'd1000;
    localparam logic signed [31:0] RST_SPEED_TOP    = 32'sh7fff_ffff;
    localparam logic signed [31:0] RST_SPEED_BOTTOM = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_LOAD_POS,
        ACT_LOAD_VEL,
        ACT_LOAD_ACC
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MERGE,
        ST_DIV_E,
        ST_TAKE_E,
        ST_DIV_STEP,
        ST_MUL,
        ST_DIV_W,
        ST_SEEK,
        ST_INTEG,
        ST_LOAD,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        LC_NONE,
        LC_DIFF,
        LC_DIV_E,
        LC_TAKE_E,
        LC_DIV_STEP,
        LC_MUL,
        LC_DIV_W,
        LC_SEEK,
        LC_INTEG,
        LC_LOAD_POS,
        LC_LOAD_VEL,
        LC_LOAD_ACC
    } t_lane_cmd;

    typedef struct packed {
        t_lane_cmd cmd;
        logic      seek;
        logic      scale;
        logic      dmax_zero;
        logic      reclamp;
    } t_lane_ctl;

    typedef struct packed {
        logic busy;
    } t_lane_sts;

endpackage

[design/three_axis_homing_kinematics_core.sv]
// a load or a tick without homing passes its load or integrate state, then the done state
// a homing tick adds offset, merge, divide, multiply and seek states, paced by the lane divider
// the done state waits for the result register to free up before loading it
// one item is in flight at a time; the next beat is taken while the result waits in its register
// synchronous active-low reset: position, velocity and acceleration to zero, registers to defaults
// depends on thkc_pkg, thkc_lane, thkc_merge and the defines header
module three_axis_homing_kinematics_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [thkc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    // input beat
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic signed [31:0]                i_arg_x,
    input  logic signed [31:0]                i_arg_y,
    input  logic signed [31:0]                i_arg_z,
    // result beat
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [31:0]                o_pos_x,
    output logic signed [31:0]                o_pos_y,
    output logic signed [31:0]                o_pos_z,
    output logic signed [31:0]                o_vel_x,
    output logic signed [31:0]                o_vel_y,
    output logic signed [31:0]                o_vel_z
);
    import thkc_pkg::*;

`include "three_axis_homing_kinematics_core_defines.svh"

    // configuration registers
    logic               r_homing_enable;
    logic [30:0]        r_speed;
    logic [30:0]        r_accel;
    logic [30:0]        r_range;
    logic signed [31:0] r_speed_top;
    logic signed [31:0] r_speed_bottom;
    logic signed [31:0] n_speed_top;
    logic signed [31:0] n_speed_bottom;
    logic signed [31:0] lim_lo;
    logic signed [31:0] lim_hi;
    logic [30:0]        range_eff;
    logic               reclamp;

    // sequencer
    t_state             r_state;
    t_state             n_state;
    logic               r_started;
    logic               n_started;
    t_action            r_action;
    logic signed [31:0] r_arg [3];
    t_lane_cmd          cmd;
    t_lane_ctl          ctl;
    logic               accept;
    logic               out_load;
    logic               lane_busy;

    // lanes and merge
    t_lane_sts              sts [3];
    logic [COORD_WIDTH-1:0] lane_abs [3];
    logic signed [31:0]     lane_pos [3];
    logic signed [31:0]     lane_vel [3];
    logic [COORD_WIDTH-1:0] dmax;
    logic                   dmax_scale;
    logic                   dmax_zero;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];

    // limit writes take effect on the stored velocities in the same cycle
    always_comb begin
        reclamp        = i_cfg_we && (i_cfg_index == REG_SPEED_TOP ||
                                      i_cfg_index == REG_SPEED_BOTTOM);
        n_speed_top    = (i_cfg_we && i_cfg_index == REG_SPEED_TOP) ? i_cfg_data : r_speed_top;
        n_speed_bottom = (i_cfg_we && i_cfg_index == REG_SPEED_BOTTOM) ? i_cfg_data
                                                                      : r_speed_bottom;
        lim_lo         = (n_speed_bottom < n_speed_top) ? n_speed_bottom : n_speed_top;
        lim_hi         = (n_speed_bottom < n_speed_top) ? n_speed_top : n_speed_bottom;
        // a zero stop range behaves as one
        range_eff      = (r_range == '0) ? 31'd1 : r_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_homing_enable <= 1'b0;
            r_speed         <= RST_SPEED;
            r_accel         <= RST_ACCEL;
            r_range         <= RST_RANGE;
            r_speed_top     <= RST_SPEED_TOP;
            r_speed_bottom  <= RST_SPEED_BOTTOM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOMING_ENABLE:    r_homing_enable <= i_cfg_data[0];
                REG_HOMING_MAX_SPEED: r_speed         <= i_cfg_data[30:0];
                REG_HOMING_ACCEL:     r_accel         <= i_cfg_data[30:0];
                REG_STOP_RANGE:       r_range         <= i_cfg_data[30:0];
                REG_SPEED_TOP:        r_speed_top     <= i_cfg_data;
                REG_SPEED_BOTTOM:     r_speed_bottom  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign lane_busy = sts[0].busy | sts[1].busy | sts[2].busy;

    // next state and lane commands
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        cmd       = LC_NONE;
        accept    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    accept = 1'b1;
                    if (i_action == ACT_TICK) begin
                        n_state = r_homing_enable ? ST_DIFF : ST_INTEG;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_DIFF: begin
                cmd     = LC_DIFF;
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                n_state = ST_DIV_E;
            end
            ST_DIV_E: begin
                // offsets already within the seek speed skip the scaling divide
                if (!dmax_scale) begin
                    n_state = ST_TAKE_E;
                end else if (!r_started) begin
                    cmd       = LC_DIV_E;
                    n_started = 1'b1;
                end else if (!lane_busy) begin
                    n_started = 1'b0;
                    n_state   = ST_TAKE_E;
                end
            end
            ST_TAKE_E: begin
                cmd     = LC_TAKE_E;
                n_state = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                // zero offset: the step is the full seek acceleration
                if (dmax_zero) begin
                    n_state = ST_MUL;
                end else if (!r_started) begin
                    cmd       = LC_DIV_STEP;
                    n_started = 1'b1;
                end else if (!lane_busy) begin
                    n_started = 1'b0;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd     = LC_MUL;
                n_state = ST_DIV_W;
            end
            ST_DIV_W: begin
                if (!r_started) begin
                    cmd       = LC_DIV_W;
                    n_started = 1'b1;
                end else if (!lane_busy) begin
                    n_started = 1'b0;
                    n_state   = ST_SEEK;
                end
            end
            ST_SEEK: begin
                cmd     = LC_SEEK;
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                cmd     = LC_INTEG;
                n_state = ST_DONE;
            end
            ST_LOAD: begin
                unique case (r_action)
                    ACT_LOAD_POS: cmd = LC_LOAD_POS;
                    ACT_LOAD_VEL: cmd = LC_LOAD_VEL;
                    ACT_LOAD_ACC: cmd = LC_LOAD_ACC;
                    default:      cmd = LC_NONE;
                endcase
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        ctl.cmd       = cmd;
        ctl.seek      = r_homing_enable;
        ctl.scale     = dmax_scale;
        ctl.dmax_zero = dmax_zero;
        ctl.reclamp   = reclamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    // captured input beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_arg[0] <= i_arg_x;
            r_arg[1] <= i_arg_y;
            r_arg[2] <= i_arg_z;
        end
    end

    // three axis lanes side by side
    for (genvar k = 0; k < 3; k++) begin : g_lane
        thkc_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_arg      (r_arg[k]),
            .i_speed    (r_speed),
            .i_accel    (r_accel),
            .i_range    (range_eff),
            .i_dmax     (dmax),
            .i_lim_lo   (lim_lo),
            .i_lim_hi   (lim_hi),
            .o_sts      (sts[k]),
            .o_abs_diff (lane_abs[k]),
            .o_pos      (lane_pos[k]),
            .o_vel      (lane_vel[k])
        );
    end

    // largest offset over the lanes, loaded in the cycle after the offsets
    thkc_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_load  (r_state == ST_MERGE),
        .i_abs   (lane_abs),
        .i_speed (r_speed),
        .o_dmax  (dmax),
        .o_scale (dmax_scale),
        .o_zero  (dmax_zero)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pos <= lane_pos;
            r_vel <= lane_vel;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];
    assign o_vel_x     = r_vel[0];
    assign o_vel_y     = r_vel[1];
    assign o_vel_z     = r_vel[2];

    // checks
    `THKC_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready,
        "second beat accepted while an item is in flight")
    `THKC_ASSERT_NOW(a_div_in_div_state, lane_busy,
        r_state == ST_DIV_E || r_state == ST_DIV_STEP || r_state == ST_DIV_W,
        "lane divider running outside a divide state")
    `THKC_ASSERT_NEXT(a_result_posted, out_load, o_out_valid,
        "finished item did not reach the result register")

endmodule

[design/thkc_muldiv.sv]
// bit-serial floor(a*b/c) with a <= c, one bit of b per cycle
// depends on thkc_pkg
module thkc_muldiv #(
    parameter int QW = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [QW-1:0]                  i_a,
    input  logic [thkc_pkg::DIV_BW-1:0]    i_b,
    input  logic [QW-1:0]                  i_c,
    input  logic [thkc_pkg::DIV_CNT_W-1:0] i_nbits,
    output logic                           o_busy,
    output logic [thkc_pkg::DIV_BW-1:0]    o_quot
);
    import thkc_pkg::*;

    logic [QW-1:0]        r_a;
    logic [QW-1:0]        r_c;
    logic [QW-1:0]        r_rem;
    logic [DIV_BW-1:0]    r_b;
    logic [DIV_BW-1:0]    r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [QW+1:0] t_sum;
    logic [QW+1:0] c1;
    logic [QW+1:0] c2;
    logic [QW+1:0] n_rem;
    logic [1:0]    dig;

    always_comb begin
        t_sum = {1'b0, r_rem, 1'b0} + (r_b[DIV_BW-1] ? (QW+2)'(r_a) : '0);
        c1    = (QW+2)'(r_c);
        c2    = {1'b0, r_c, 1'b0};
        if (t_sum >= c2) begin
            n_rem = t_sum - c2;
            dig   = 2'd2;
        end else if (t_sum >= c1) begin
            n_rem = t_sum - c1;
            dig   = 2'd1;
        end else begin
            n_rem = t_sum;
            dig   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_nbits;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_c    <= i_c;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem[QW-1:0];
            r_b    <= {r_b[DIV_BW-2:0], 1'b0};
            r_quot <= {r_quot[DIV_BW-2:0], 1'b0} + DIV_BW'(dig);
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

[design/thkc_merge.sv]
// merge stage: largest offset over the three lanes and its flags
// depends on thkc_pkg
module thkc_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [COORD_WIDTH-1:0] i_abs [3],
    input  logic [30:0]            i_speed,
    output logic [COORD_WIDTH-1:0] o_dmax,
    output logic                   o_scale,
    output logic                   o_zero
);
    import thkc_pkg::*;

    localparam int QW = (COORD_WIDTH > 31) ? COORD_WIDTH : 31;

    logic [COORD_WIDTH-1:0] m01;
    logic [COORD_WIDTH-1:0] n_dmax;

    always_comb begin
        m01    = (i_abs[0] > i_abs[1]) ? i_abs[0] : i_abs[1];
        n_dmax = (i_abs[2] > m01) ? i_abs[2] : m01;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_dmax  <= n_dmax;
            o_scale <= QW'(n_dmax) > QW'(i_speed);
            o_zero  <= (n_dmax == '0);
        end
    end

endmodule

[design/thkc_lane.sv]
// one axis lane: position, velocity, acceleration and seek arithmetic
// depends on thkc_pkg and thkc_muldiv
module thkc_lane #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  thkc_pkg::t_lane_ctl     i_ctl,
    input  logic signed [31:0]      i_arg,
    input  logic [30:0]             i_speed,
    input  logic [30:0]             i_accel,
    input  logic [30:0]             i_range,
    input  logic [COORD_WIDTH-1:0]  i_dmax,
    input  logic signed [31:0]      i_lim_lo,
    input  logic signed [31:0]      i_lim_hi,
    output thkc_pkg::t_lane_sts     o_sts,
    output logic [COORD_WIDTH-1:0]  o_abs_diff,
    output logic signed [31:0]      o_pos,
    output logic signed [31:0]      o_vel
);
    import thkc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int QW = (CW > 31) ? CW : 31;

    function automatic logic signed [31:0] clamp_lim(input logic signed [34:0] v,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
        logic signed [31:0] res;
        if (v > 35'(hi)) begin
            res = hi;
        end else if (v < 35'(lo)) begin
            res = lo;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic signed [CW-1:0] r_pos;
    logic signed [31:0]   r_vel;
    logic signed [31:0]   r_acc;
    logic signed [CW:0]   r_d;
    logic [CW-1:0]        r_ad;
    logic signed [31:0]   r_e;
    logic [30:0]          r_step;
    logic [61:0]          r_prod;
    logic signed [33:0]   r_vseek;

    logic signed [CW-1:0] tgt;
    logic signed [CW:0]   diff;
    logic [CW:0]          diff_abs;
    logic                 div_start;
    logic [QW-1:0]        div_a;
    logic [DIV_BW-1:0]    div_b;
    logic [QW-1:0]        div_c;
    logic [DIV_CNT_W-1:0] div_n;
    logic                 div_busy;
    logic [DIV_BW-1:0]    div_q;
    logic [47:0]          gain;
    logic signed [31:0]   e_mag;
    logic signed [31:0]   e_val;
    logic signed [31:0]   e_neg;
    logic [30:0]          abs_e;
    logic [31:0]          q16;
    logic [30:0]          n_step;
    logic signed [62:0]   w_mag;
    logic signed [62:0]   w_val;
    logic signed [33:0]   vel34;
    logic signed [33:0]   step_s;
    logic signed [33:0]   v_lo;
    logic signed [33:0]   v_hi;
    logic signed [33:0]   n_vseek;
    logic signed [33:0]   base;
    logic signed [34:0]   sum;
    logic signed [31:0]   v_integ;

    always_comb begin
        tgt      = CW'(i_arg);
        diff     = (CW+1)'(tgt) - (CW+1)'(r_pos);
        diff_abs = diff[CW] ? -diff : diff;
        gain     = 48'(ACC_GAIN_Q16) * 48'(i_accel);

        div_start = 1'b0;
        div_a     = QW'(r_ad);
        div_b     = {i_speed, 31'b0};
        div_c     = QW'(i_dmax);
        div_n     = E_BITS;
        case (i_ctl.cmd)
            LC_DIV_E: begin
                div_start = 1'b1;
            end
            LC_DIV_STEP: begin
                div_start = 1'b1;
                div_b     = {gain, 14'b0};
                div_n     = STEP_BITS;
            end
            LC_DIV_W: begin
                div_start = 1'b1;
                div_a     = QW'(1);
                div_b     = r_prod;
                div_c     = QW'(i_range);
                div_n     = W_BITS;
            end
            default: begin
            end
        endcase

        // scaled offset takes the sign of the raw offset
        e_mag = {1'b0, div_q[30:0]};
        e_val = i_ctl.scale ? (r_d[CW] ? -e_mag : e_mag) : 32'(r_d);
        e_neg = -r_e;
        abs_e = r_e[31] ? e_neg[30:0] : r_e[30:0];

        q16    = div_q[47:16];
        n_step = i_ctl.dmax_zero ? i_accel :
                 ((q16 > {1'b0, i_accel}) ? i_accel : q16[30:0]);

        w_mag  = {1'b0, div_q};
        w_val  = r_e[31] ? -w_mag : w_mag;
        vel34  = 34'(r_vel);
        step_s = {3'b000, r_step};
        v_lo   = vel34 - step_s;
        v_hi   = vel34 + step_s;
        if (w_val < 63'(v_lo)) begin
            n_vseek = v_lo;
        end else if (w_val > 63'(v_hi)) begin
            n_vseek = v_hi;
        end else begin
            n_vseek = w_val[33:0];
        end

        base    = i_ctl.seek ? r_vseek : vel34;
        sum     = 35'(base) + 35'(r_acc);
        v_integ = clamp_lim(sum, i_lim_lo, i_lim_hi);
    end

    thkc_muldiv #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_b     (div_b),
        .i_c     (div_c),
        .i_nbits (div_n),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_acc <= '0;
        end else if (i_ctl.reclamp) begin
            r_vel <= clamp_lim(35'(r_vel), i_lim_lo, i_lim_hi);
        end else begin
            case (i_ctl.cmd)
                LC_SEEK:     r_vel <= n_vseek[31:0];
                LC_INTEG: begin
                    r_vel <= v_integ;
                    r_pos <= r_pos + CW'(v_integ);
                end
                LC_LOAD_POS: r_pos <= tgt;
                LC_LOAD_VEL: r_vel <= clamp_lim(35'(i_arg), i_lim_lo, i_lim_hi);
                LC_LOAD_ACC: r_acc <= i_arg;
                default: begin
                end
            endcase
        end
    end

    // seek working registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            LC_DIFF: begin
                r_d  <= diff;
                r_ad <= diff_abs[CW-1:0];
            end
            LC_TAKE_E: r_e <= e_val;
            LC_MUL: begin
                r_step <= n_step;
                r_prod <= 62'(i_speed) * 62'(abs_e);
            end
            LC_SEEK:   r_vseek <= n_vseek;
            default: begin
            end
        endcase
    end

    assign o_sts.busy = div_busy;
    assign o_abs_diff = r_ad;
    assign o_pos      = 32'(r_pos);
    assign o_vel      = r_vel;

endmodule

[tb/tb_three_axis_homing_kinematics_core.sv]
// testbench for three_axis_homing_kinematics_core: directed and random beats checked
// against an in-bench predictor of the seek, integration and load behavior
// depends on thkc_pkg and the core rtl
`timescale 1ns / 1ps

module tb_three_axis_homing_kinematics_core;
    import thkc_pkg::*;

    localparam int  CLK_HALF    = 10;
    localparam int  DRAIN_WAIT  = 200;    // longer than the slowest homing tick
    localparam int  LIMIT_CYC   = 3000000;

    // expected beat on the result channel
    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
    } t_motion;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_action            action = ACT_TICK;
    logic signed [31:0] arg_x = '0, arg_y = '0, arg_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;

    // idling controls, changed between phases
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int errors = 0;

    t_motion motion_q [$];

    // predictor state and register copies
    longint pos_m [3], vel_m [3], acc_m [3];
    bit     hom_en;
    longint seek_speed, seek_accel, stop_rng, spd_top, spd_bot;

    three_axis_homing_kinematics_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_action   (action),
        .i_arg_x    (arg_x),
        .i_arg_y    (arg_y),
        .i_arg_z    (arg_z),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_pos_x    (pos_x),
        .o_pos_y    (pos_y),
        .o_pos_z    (pos_z),
        .o_vel_x    (vel_x),
        .o_vel_y    (vel_y),
        .o_vel_z    (vel_z)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_vel(longint v);
        longint lo, hi;
        lo = (spd_bot < spd_top) ? spd_bot : spd_top;
        hi = (spd_bot < spd_top) ? spd_top : spd_bot;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor(a*b/c) with a full-width product
    function automatic longint unsigned scale_div(longint unsigned a, longint unsigned b,
                                                  longint unsigned c);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return 64'(prod / 128'(c));
    endfunction

    // pull each velocity toward the target-seeking speed
    function automatic void seek_target(longint tgt [3]);
        longint          d [3];
        longint unsigned ad [3];
        longint unsigned dmax, step, m;
        longint          e, w, lo, hi, rng;
        dmax = 0;
        rng = (stop_rng != 0) ? stop_rng : 1;
        for (int k = 0; k < 3; k++) begin
            d[k]  = tgt[k] - pos_m[k];
            ad[k] = (d[k] < 0) ? -d[k] : d[k];
            if (ad[k] > dmax) dmax = ad[k];
        end
        for (int k = 0; k < 3; k++) begin
            e = d[k];
            if (dmax > seek_speed) begin
                m = scale_div(ad[k], seek_speed, dmax);
                e = (d[k] < 0) ? -longint'(m) : longint'(m);
            end
            if (dmax == 0) begin
                step = seek_accel;
            end else begin
                step = scale_div(longint'(ACC_GAIN_Q16) * seek_accel, ad[k], dmax) >> 16;
                if (step > seek_accel) step = seek_accel;
            end
            w  = (seek_speed * e) / rng;
            lo = vel_m[k] - longint'(step);
            hi = vel_m[k] + longint'(step);
            vel_m[k] = (w < lo) ? lo : ((w > hi) ? hi : w);
        end
    endfunction

    // advance the predicted state by one accepted beat and queue its result
    function automatic void predict_motion(t_action act, logic signed [31:0] ax,
                                           logic signed [31:0] ay, logic signed [31:0] az);
        longint  a [3];
        t_motion r;
        a[0] = ax; a[1] = ay; a[2] = az;
        case (act)
            ACT_TICK: begin
                if (hom_en) seek_target(a);
                for (int k = 0; k < 3; k++) begin
                    vel_m[k] = clamp_vel(vel_m[k] + acc_m[k]);
                    pos_m[k] = longint'(int'(pos_m[k] + vel_m[k]));
                end
            end
            ACT_LOAD_POS: for (int k = 0; k < 3; k++) pos_m[k] = a[k];
            ACT_LOAD_VEL: for (int k = 0; k < 3; k++) vel_m[k] = clamp_vel(a[k]);
            default:      for (int k = 0; k < 3; k++) acc_m[k] = a[k];
        endcase
        for (int k = 0; k < 3; k++) begin
            r.pos[k] = pos_m[k][31:0];
            r.vel[k] = vel_m[k][31:0];
        end
        motion_q.push_back(r);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 field, $signed(got), $signed(exp), $realtime);
        errors++;
    endtask

    // result side: compare each beat, then pick the next ready
    always @(posedge i_clk) begin
        t_motion x;
        if (i_rst_n && out_valid && out_ready) begin
            if (motion_q.size() == 0) begin
                report_mismatch("unexpected beat", pos_x, 32'd0);
            end else begin
                x = motion_q.pop_front();
                if (pos_x !== x.pos[0]) report_mismatch("pos_x", pos_x, x.pos[0]);
                if (pos_y !== x.pos[1]) report_mismatch("pos_y", pos_y, x.pos[1]);
                if (pos_z !== x.pos[2]) report_mismatch("pos_z", pos_z, x.pos[2]);
                if (vel_x !== x.vel[0]) report_mismatch("vel_x", vel_x, x.vel[0]);
                if (vel_y !== x.vel[1]) report_mismatch("vel_y", vel_y, x.vel[1]);
                if (vel_z !== x.vel[2]) report_mismatch("vel_z", vel_z, x.vel[2]);
            end
        end
        // long hold-off counted here so the core backs up into its input
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------- drivers

    // one beat; valid stays high afterward until the caller lowers it
    task automatic send_beat(t_action act, logic signed [31:0] ax,
                             logic signed [31:0] ay, logic signed [31:0] az);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        arg_x    <= ax;
        arg_y    <= ay;
        arg_z    <= az;
        do @(posedge i_clk); while (!in_ready);
        predict_motion(act, ax, ay, az);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (motion_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write while the core is idle; the predictor copy follows
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_HOMING_ENABLE:    hom_en = value[0];
            REG_HOMING_MAX_SPEED: seek_speed = value[30:0];
            REG_HOMING_ACCEL:     seek_accel = value[30:0];
            REG_STOP_RANGE:       stop_rng = value[30:0];
            REG_SPEED_TOP, REG_SPEED_BOTTOM: begin
                if (idx == REG_SPEED_TOP) spd_top = $signed(value);
                else                      spd_bot = $signed(value);
                for (int k = 0; k < 3; k++) vel_m[k] = clamp_vel(vel_m[k]);
            end
            default: ;
        endcase
    endtask

    // mix of full range, extremes and small values
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(4000)) - 2000;
            3:       return $signed($urandom_range(2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    // target offset around the predicted position, mostly reachable distances
    function automatic logic signed [31:0] pick_target(int k);
        longint off;
        case ($urandom_range(9))
            0:       return $urandom;
            1:       off = 0;
            2, 3:    off = longint'($urandom_range(200)) - 100;
            default: off = longint'($urandom_range(200000)) - 100000;
        endcase
        return 32'(pos_m[k] + off);
    endfunction

    function automatic logic [31:0] pick_pos31();
        case ($urandom_range(4))
            0:       return 32'h7fff_ffff;
            1:       return 32'd0;
            2:       return $urandom_range(5000);
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_beat(ACT_TICK, 0, 0, 0);
        send_beat(ACT_LOAD_POS, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_beat(ACT_LOAD_VEL, 32'sh7fff_ffff, 32'sh8000_0000, -5);
        send_beat(ACT_TICK, 0, 0, 0);          // position wraps
        send_beat(ACT_LOAD_ACC, 32'sh7fff_ffff, 32'sh8000_0000, 3);
        send_beat(ACT_TICK, 0, 0, 0);          // velocity saturates at the limits
        send_beat(ACT_LOAD_ACC, 0, 0, 0);
        send_beat(ACT_LOAD_VEL, 0, 0, 0);
        send_beat(ACT_LOAD_POS, 100, -200, 300);
        wait_drained();
        write_reg(REG_HOMING_ENABLE, 32'd1);
        write_reg(3'd6, 32'hffff_ffff);        // unused indexes are ignored
        write_reg(3'd7, 32'hffff_ffff);
        send_beat(ACT_TICK, 100, -200, 300);   // zero largest offset
        send_beat(ACT_TICK, 50100, -200, 300); // beyond seek speed, scaled
        send_beat(ACT_TICK, 150, -180, 310);   // within seek speed
        send_beat(ACT_TICK, 32'sh8000_0000, 32'sh7fff_ffff, 0);
        wait_drained();
        write_reg(REG_STOP_RANGE, 32'd0);      // acts as one
        write_reg(REG_HOMING_ACCEL, 32'h7fff_ffff);
        write_reg(REG_HOMING_MAX_SPEED, 32'hffff_ffff);
        send_beat(ACT_TICK, 32'sh7fff_ffff, 32'sh8000_0000, 12345);
        send_beat(ACT_TICK, 0, 0, 0);
        wait_drained();
        write_reg(REG_SPEED_TOP, -32'sd500);   // swapped limits, re-clamps velocity
        write_reg(REG_SPEED_BOTTOM, 32'sd700);
        send_beat(ACT_LOAD_VEL, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_beat(ACT_TICK, 99, 98, 97);
        wait_drained();
        write_reg(REG_HOMING_ACCEL, 32'd0);
        write_reg(REG_SPEED_TOP, 32'sh7fff_ffff);
        write_reg(REG_SPEED_BOTTOM, 32'sh8000_0000);
        send_beat(ACT_TICK, 1000, 1000, 1000);
        wait_drained();
    endtask

    // random registers for a phase; extremes come up often
    task automatic randomize_regs();
        write_reg(REG_HOMING_ENABLE, 32'($urandom_range(9) != 0));
        write_reg(REG_HOMING_MAX_SPEED, pick_pos31());
        write_reg(REG_HOMING_ACCEL, pick_pos31());
        write_reg(REG_STOP_RANGE, ($urandom_range(6) == 0) ? 32'd0 : pick_pos31());
        write_reg(REG_SPEED_TOP, ($urandom_range(2) == 0) ? 32'sh7fff_ffff : pick_value());
        write_reg(REG_SPEED_BOTTOM, ($urandom_range(2) == 0) ? 32'sh8000_0000 : pick_value());
    endtask

    task automatic test_random(int n_beats, int tx_pct, int rx_pct);
        t_action act;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        randomize_regs();
        for (int i = 0; i < n_beats; i++) begin
            if ($urandom_range(99) < 80) begin
                send_beat(ACT_TICK, pick_target(0), pick_target(1), pick_target(2));
            end else begin
                act = t_action'($urandom_range(3));
                if (act == ACT_LOAD_ACC && $urandom_range(1))
                    send_beat(act, $signed($urandom_range(200)) - 100,
                              $signed($urandom_range(200)) - 100,
                              $signed($urandom_range(200)) - 100);
                else
                    send_beat(act, pick_value(), pick_value(), pick_value());
            end
            if (i % 60 == 59) begin
                wait_drained();
                randomize_regs();
            end
        end
        wait_drained();
    endtask

    // receiver holds off while beats keep coming, then the sender waits for all
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 600;
        for (int i = 0; i < 8; i++)
            send_beat(ACT_TICK, pick_target(0), pick_target(1), pick_target(2));
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < 3; k++) begin
            pos_m[k] = 0; vel_m[k] = 0; acc_m[k] = 0;
        end
        hom_en = 1'b0;
        seek_speed = RST_SPEED;
        seek_accel = RST_ACCEL;
        stop_rng = RST_RANGE;
        spd_top = RST_SPEED_TOP;
        spd_bot = RST_SPEED_BOTTOM;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300, 0, 0);
        test_random(240, 83, 0);
        test_random(240, 0, 83);
        test_random(240, 37, 37);
        test_backpressure();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYC) @(posedge i_clk);
        $display("timeout with %0d beats outstanding", motion_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/thkc_pkg.sv
design/thkc_muldiv.sv
design/thkc_merge.sv
design/thkc_lane.sv
design/three_axis_homing_kinematics_core.sv
tb/tb_three_axis_homing_kinematics_core.sv
